/* rtl/cal_pkg.sv */
`default_nettype none
package cal_pkg;

  localparam int DATA_W           = 32;
  localparam int CNT_W            = 7;
  localparam int STORE_DEPTH      = 64;
  localparam int CAPACITY_DEFAULT = 64;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_READ_ALL = 2'd1,
    OP_UPDATE   = 2'd2,
    OP_DELETE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic [CNT_W-1:0]           position;
    logic signed [DATA_W-1:0]   new_value;
  } in_t;

  typedef struct packed {
    status_t                    status;
    logic signed [DATA_W-1:0]   element;
    logic [CNT_W-1:0]           element_count;
    logic                       last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_ISSUE,
    S_RD_LOAD,
    S_DEL_RD,
    S_DEL_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    idx_zero;
    logic    idx_inc;
    logic    mem_we;
    logic    waddr_idx;
    logic    wdata_mem;
    logic    mem_re;
    logic    raddr_next;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_t out_status;
    logic    out_elem_mem;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    full;
    logic    empty;
    logic    pos_ok;
    logic    idx_last;
    logic    slot_free;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/cal_ram.sv */
`default_nettype none
module cal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/cal_ctrl.sv */
`default_nettype none
module cal_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cal_pkg::stat_t  stat,
  output cal_pkg::cmd_t        cmd
);

  cal_pkg::state_t  state_r, state_nxt;
  cal_pkg::status_t resp_r, resp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cal_pkg::S_IDLE;
      resp_r  <= cal_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    case (state_r)
      cal_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = cal_pkg::S_DECIDE;
        end
      end
      cal_pkg::S_DECIDE: begin
        case (stat.opcode)
          cal_pkg::OP_APPEND: begin
            resp_nxt  = stat.full ? cal_pkg::ST_FULL : cal_pkg::ST_OK;
            state_nxt = cal_pkg::S_RESP;
          end
          cal_pkg::OP_READ_ALL: begin
            if (stat.empty) begin
              resp_nxt  = cal_pkg::ST_EMPTY;
              state_nxt = cal_pkg::S_RESP;
            end else begin
              state_nxt = cal_pkg::S_RD_ISSUE;
            end
          end
          cal_pkg::OP_UPDATE: begin
            resp_nxt  = stat.pos_ok ? cal_pkg::ST_OK : cal_pkg::ST_BAD_POS;
            state_nxt = cal_pkg::S_RESP;
          end
          cal_pkg::OP_DELETE: begin
            if (stat.pos_ok) begin
              state_nxt = cal_pkg::S_DEL_RD;
            end else begin
              resp_nxt  = cal_pkg::ST_BAD_POS;
              state_nxt = cal_pkg::S_RESP;
            end
          end
          default: state_nxt = cal_pkg::S_IDLE;
        endcase
      end
      cal_pkg::S_RD_ISSUE: state_nxt = cal_pkg::S_RD_LOAD;
      cal_pkg::S_RD_LOAD: begin
        if (stat.slot_free) begin
          state_nxt = stat.idx_last ? cal_pkg::S_IDLE : cal_pkg::S_RD_ISSUE;
        end
      end
      cal_pkg::S_DEL_RD: begin
        if (stat.idx_last) begin
          resp_nxt  = cal_pkg::ST_OK;
          state_nxt = cal_pkg::S_RESP;
        end else begin
          state_nxt = cal_pkg::S_DEL_WR;
        end
      end
      cal_pkg::S_DEL_WR: state_nxt = cal_pkg::S_DEL_RD;
      cal_pkg::S_RESP: begin
        if (stat.slot_free) begin
          state_nxt = cal_pkg::S_IDLE;
        end
      end
      default: state_nxt = cal_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.out_status = cal_pkg::ST_OK;
    in_ready     = 1'b0;
    case (state_r)
      cal_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      cal_pkg::S_DECIDE: begin
        case (stat.opcode)
          cal_pkg::OP_APPEND: begin
            cmd.mem_we  = !stat.full;
            cmd.cnt_inc = !stat.full;
          end
          cal_pkg::OP_READ_ALL: cmd.idx_zero = 1'b1;
          cal_pkg::OP_UPDATE: begin
            cmd.mem_we    = stat.pos_ok;
            cmd.waddr_idx = 1'b1;
          end
          default: ;
        endcase
      end
      cal_pkg::S_RD_ISSUE: cmd.mem_re = 1'b1;
      cal_pkg::S_RD_LOAD: begin
        cmd.out_load     = stat.slot_free;
        cmd.out_elem_mem = 1'b1;
        cmd.out_last     = stat.idx_last;
        cmd.idx_inc      = stat.slot_free && !stat.idx_last;
      end
      cal_pkg::S_DEL_RD: begin
        // fetch the element above the gap, or close the list when none is left
        cmd.mem_re     = !stat.idx_last;
        cmd.raddr_next = 1'b1;
        cmd.cnt_dec    = stat.idx_last;
      end
      cal_pkg::S_DEL_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.waddr_idx = 1'b1;
        cmd.wdata_mem = 1'b1;
        cmd.idx_inc   = 1'b1;
      end
      cal_pkg::S_RESP: begin
        cmd.out_load   = stat.slot_free;
        cmd.out_status = resp_r;
        cmd.out_last   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/cal_dp.sv */
`default_nettype none
module cal_dp #(
  parameter int CAPACITY = cal_pkg::CAPACITY_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cal_pkg::in_t   in_data,
  input  wire cal_pkg::cmd_t  cmd,
  output cal_pkg::stat_t      stat,
  output logic                out_valid,
  input  wire logic           out_ready,
  output cal_pkg::out_t       out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [cal_pkg::CNT_W-1:0] CAP_CNT = cal_pkg::CNT_W'(CAPACITY);

  cal_pkg::opcode_t                  op_r;
  logic [cal_pkg::CNT_W-1:0]         pos_r;
  logic [cal_pkg::DATA_W-1:0]        val_r;
  logic [cal_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [cal_pkg::CNT_W-1:0]         idx_r, idx_nxt;
  logic                              out_valid_r, out_valid_nxt;
  cal_pkg::out_t                     out_data_r;

  logic [cal_pkg::CNT_W:0]           idx_plus1;
  logic [AW-1:0]                     waddr, raddr;
  logic [cal_pkg::DATA_W-1:0]        wdata, rdata;

  assign idx_plus1 = {1'b0, idx_r} + {{cal_pkg::CNT_W{1'b0}}, 1'b1};
  assign waddr     = cmd.waddr_idx  ? idx_r[AW-1:0] : count_r[AW-1:0];
  assign raddr     = cmd.raddr_next ? idx_plus1[AW-1:0] : idx_r[AW-1:0];
  assign wdata     = cmd.wdata_mem  ? rdata : val_r;

  cal_ram #(
    .WIDTH (cal_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.latch_in) begin
      // position is 1-based
      idx_nxt = in_data.position - 1'b1;
    end else if (cmd.idx_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_plus1[cal_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch_in) begin
      op_r  <= in_data.opcode;
      pos_r <= in_data.position;
      val_r <= in_data.new_value;
    end
    if (cmd.out_load) begin
      out_data_r.status        <= cmd.out_status;
      out_data_r.element       <= cmd.out_elem_mem ? rdata : '0;
      out_data_r.element_count <= count_r;
      out_data_r.last          <= cmd.out_last;
    end
  end

  always_comb begin
    stat.opcode    = op_r;
    stat.full      = count_r >= CAP_CNT;
    stat.empty     = count_r == '0;
    stat.pos_ok    = (pos_r != '0) && (pos_r <= count_r);
    stat.idx_last  = idx_plus1 >= {1'b0, count_r};
    stat.slot_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* rtl/compacting_array_list_top.sv */
`default_nettype none
// Bounded list of signed 32-bit words held packed at the front of a
// CAPACITY-entry RAM. Append, update and invalid commands give one result,
// loaded by a response state after the decide state; a read-out of n elements
// gives n results (one RAM read then an output load each); a delete at
// position p on a list of n elements reads each later element and writes it
// back one place down through the single RAM port pair. A new command is taken
// once the previous one has placed its last result in the output register,
// which may still be waiting to be taken.
module compacting_array_list_top #(
  parameter int CAPACITY = cal_pkg::CAPACITY_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cal_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cal_pkg::out_t      out_data
);

  cal_pkg::cmd_t  cmd;
  cal_pkg::stat_t stat;

  cal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cal_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEFAULT;
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  compacting_array_list_top #(.CAPACITY(LIST_CAP)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the list and the results still owed by the block
  logic signed [DATA_W-1:0] shadow_list[$];
  out_t                     pending_results[$];

  int  commands_sent;
  int  results_checked;
  int  mismatches;
  int  peak_size;
  int  stall_left;
  bit  no_gaps;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("tb_top failed");
    $finish;
  end

  function automatic out_t make_result(status_t st, logic signed [DATA_W-1:0] elem, int n,
                                       bit fin);
    out_t r;
    r.status        = st;
    r.element       = elem;
    r.element_count = CNT_W'(n);
    r.last          = fin;
    return r;
  endfunction

  function automatic in_t make_command(opcode_t op, int pos, logic signed [DATA_W-1:0] v);
    in_t c;
    c.opcode    = op;
    c.position  = CNT_W'(pos);
    c.new_value = v;
    return c;
  endfunction

  // Work out the results of one accepted command and update the shadow list
  function automatic void predict_command(in_t cmd);
    int n;
    int p;
    n = shadow_list.size();
    p = int'(cmd.position);
    case (cmd.opcode)
      OP_APPEND: begin
        if (n >= LIST_CAP) begin
          pending_results.push_back(make_result(ST_FULL, '0, n, 1'b1));
        end else begin
          shadow_list.push_back(cmd.new_value);
          pending_results.push_back(make_result(ST_OK, '0, n + 1, 1'b1));
        end
      end
      OP_READ_ALL: begin
        if (n == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            pending_results.push_back(make_result(ST_OK, shadow_list[i], n, i == n - 1));
        end
      end
      OP_UPDATE: begin
        if (p < 1 || p > n) begin
          pending_results.push_back(make_result(ST_BAD_POS, '0, n, 1'b1));
        end else begin
          shadow_list[p - 1] = cmd.new_value;
          pending_results.push_back(make_result(ST_OK, '0, n, 1'b1));
        end
      end
      default: begin
        if (p < 1 || p > n) begin
          pending_results.push_back(make_result(ST_BAD_POS, '0, n, 1'b1));
        end else begin
          shadow_list.delete(p - 1);
          pending_results.push_back(make_result(ST_OK, '0, n - 1, 1'b1));
        end
      end
    endcase
    if (shadow_list.size() > peak_size) peak_size = shadow_list.size();
  endfunction

  // Offer one item from the falling edge and hold it until the block takes it
  task automatic send_command(in_t cmd);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    predict_command(cmd);
    commands_sent++;
  endtask

  function automatic int pick_position();
    int n;
    n = shadow_list.size();
    if (n > 0 && $urandom_range(99) < 80) return $urandom_range(n, 1);
    case ($urandom_range(2))
      0:       return 0;
      1:       return n + 1;
      default: return $urandom_range(127);
    endcase
  endfunction

  function automatic in_t pick_command(mix_t mix);
    int roll;
    int app_w;
    int upd_w;
    opcode_t op;
    roll = $urandom_range(99);
    case (mix)
      MIX_GROW:   begin app_w = 55; upd_w = 15; end
      MIX_SHRINK: begin app_w = 15; upd_w = 20; end
      default:    begin app_w = 30; upd_w = 30; end
    endcase
    // reads are a steady tenth; deletes take what is left
    if (roll < app_w)              op = OP_APPEND;
    else if (roll < app_w + 10)    op = OP_READ_ALL;
    else if (roll < app_w + 10 + upd_w) op = OP_UPDATE;
    else                           op = OP_DELETE;
    return make_command(op, pick_position(), $urandom);
  endfunction

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= 22);
      end
    end
  end

  function automatic bit field_ok(string name, longint want, longint got);
    if (want != got)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return want == got;
  endfunction

  always @(posedge clk) begin
    out_t want;
    bit   good;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        good = 1'b1;
        if (want.status !== out_data.status) begin
          $display("%0t: status mismatch, expected %s, actual %0d", $time, want.status.name(),
                   out_data.status);
          good = 1'b0;
        end
        if ($isunknown(out_data)) begin
          $display("%0t: unknown bits in result, expected %p, actual %p", $time, want, out_data);
          good = 1'b0;
        end else begin
          good &= field_ok("element", want.element, out_data.element);
          good &= field_ok("element_count", want.element_count, out_data.element_count);
          good &= field_ok("last", want.last, out_data.last);
        end
        if (!good) mismatches++;
      end
    end
  end

  task automatic test_empty_list();
    send_command(make_command(OP_READ_ALL, $urandom_range(127), $urandom));
    send_command(make_command(OP_UPDATE, 1, 32'sh1234_5678));
    send_command(make_command(OP_DELETE, 0, $urandom));
    send_command(make_command(OP_DELETE, 1, $urandom));
    send_command(make_command(OP_UPDATE, 127, -32'sd1));
  endtask

  task automatic test_basic_ops();
    send_command(make_command(OP_APPEND, $urandom_range(127), 32'sh7FFF_FFFF));
    send_command(make_command(OP_APPEND, $urandom_range(127), 32'sh8000_0000));
    send_command(make_command(OP_APPEND, $urandom_range(127), 32'sd0));
    send_command(make_command(OP_APPEND, $urandom_range(127), -32'sd1));
    send_command(make_command(OP_READ_ALL, $urandom_range(127), $urandom));
    send_command(make_command(OP_UPDATE, 0, 32'sh5555_5555));
    send_command(make_command(OP_UPDATE, 5, 32'sh5555_5555));
    send_command(make_command(OP_UPDATE, 4, 32'sd1));
    send_command(make_command(OP_UPDATE, 1, 32'shAAAA_AAAA));
    // delete the head, then the tail
    send_command(make_command(OP_DELETE, 1, $urandom));
    send_command(make_command(OP_DELETE, 3, $urandom));
    send_command(make_command(OP_DELETE, 64, $urandom));
    send_command(make_command(OP_DELETE, 127, $urandom));
    send_command(make_command(OP_READ_ALL, $urandom_range(127), $urandom));
  endtask

  task automatic test_fill_and_overflow();
    while (shadow_list.size() < LIST_CAP)
      send_command(make_command(OP_APPEND, $urandom_range(127), $urandom));
    repeat (3) send_command(make_command(OP_APPEND, $urandom_range(127), $urandom));
    send_command(make_command(OP_READ_ALL, $urandom_range(127), $urandom));
    send_command(make_command(OP_UPDATE, LIST_CAP, $urandom));
    send_command(make_command(OP_UPDATE, LIST_CAP + 1, $urandom));
    send_command(make_command(OP_DELETE, LIST_CAP, $urandom));
    send_command(make_command(OP_APPEND, $urandom_range(127), $urandom));
    // longest shift: remove the head of a full list
    send_command(make_command(OP_DELETE, 1, $urandom));
    send_command(make_command(OP_APPEND, $urandom_range(127), $urandom));
    send_command(make_command(OP_READ_ALL, $urandom_range(127), $urandom));
  endtask

  task automatic test_output_backpressure();
    send_command(make_command(OP_READ_ALL, $urandom_range(127), $urandom));
    stall_left = 300;
    repeat (8) send_command(pick_command(MIX_EVEN));
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (40) send_command(pick_command(MIX_EVEN));
    no_gaps = 1'b0;
  endtask

  task automatic test_random_mix();
    mix_t mix;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0:       mix = MIX_SHRINK;
        1:       mix = MIX_GROW;
        default: mix = MIX_EVEN;
      endcase
      repeat (40) send_command(pick_command(mix));
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    no_gaps  = 1'b0;
    stall_left = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_basic_ops();
    test_fill_and_overflow();
    test_output_backpressure();
    test_back_to_back();
    test_random_mix();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d commands and %0d results over all four operations,",
             commands_sent, results_checked);
    $display("list sizes 0 to %0d, full, empty and bad-position cases, %0d mismatches.",
             peak_size, mismatches);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cal_pkg.sv
rtl/cal_ram.sv
rtl/cal_ctrl.sv
rtl/cal_dp.sv
rtl/compacting_array_list_top.sv
bench/tb_top.sv
